[rtl/acs_pkg.sv]
// Shared types and constants for the ADC count scaler.
`default_nettype none
package acs_pkg;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int MAX_COUNT_W  = 24;
  localparam int VREF_W       = 16;
  localparam int RES_W        = 5;
  localparam int RANGE_W      = 24;
  localparam int DIFF_W       = RANGE_W + 1;
  localparam int MV_W         = 32;
  localparam int PCT_W        = 32;
  localparam int PROD_X_W     = MAX_COUNT_W + VREF_W + 1;
  localparam int PCT_FULL_Q8  = 25600;
  localparam int PCT_FULL_W   = 15;
  localparam int NUM_W        = RANGE_W + PCT_FULL_W;
  localparam int DIV_STEPS    = MV_W;

  localparam int DEF_COUNT_BITS    = 24;
  localparam int DEF_RESISTOR_BITS = 24;

  localparam logic [VREF_W-1:0]  RST_VREF  = 16'd3300;
  localparam logic [RES_W-1:0]   RST_RES   = 5'd12;
  localparam logic [RANGE_W-1:0] RST_PMIN  = 24'd0;
  localparam logic [RANGE_W-1:0] RST_PMAX  = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    MODE_RAW = 2'd0,
    MODE_PCT = 2'd1,
    MODE_DIV = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_VREF  = 3'd1,
    REG_RES   = 3'd2,
    REG_R1    = 3'd3,
    REG_R2    = 3'd4,
    REG_PMIN  = 3'd5,
    REG_PMAX  = 3'd6,
    REG_CLAMP = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    mode_t                  mode;
    logic                   err;
    logic                   big;
    logic                   neg;
    logic                   ovf;
    logic [MV_W-1:0]        u;
    logic [MAX_COUNT_W-1:0] raw;
  } side_t;

endpackage
`default_nettype wire

[rtl/acs_front.sv]
// Front pipeline: products, range, divider operand set-up and overflow check.
`default_nettype none
module acs_front #(
  parameter int COUNT_BITS    = acs_pkg::DEF_COUNT_BITS,
  parameter int RESISTOR_BITS = acs_pkg::DEF_RESISTOR_BITS,
  parameter int DW            = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [COUNT_BITS-1:0]        in_count,
  input  wire acs_pkg::mode_t               cfg_mode,
  input  wire logic [acs_pkg::VREF_W-1:0]   cfg_vref,
  input  wire logic [acs_pkg::RES_W-1:0]    cfg_res,
  input  wire logic [RESISTOR_BITS-1:0]     cfg_r1,
  input  wire logic [RESISTOR_BITS-1:0]     cfg_r2,
  input  wire logic [acs_pkg::RANGE_W-1:0]  cfg_pmin,
  input  wire logic [acs_pkg::RANGE_W-1:0]  cfg_pmax,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [DW-1:0]                     out_rem,
  output logic [acs_pkg::MV_W-1:0]          out_qlo,
  output logic [DW-1:0]                     out_dsr,
  output acs_pkg::side_t                    out_side
);
  import acs_pkg::*;

  localparam int NW = MV_W + RESISTOR_BITS;

  logic en_a, en_b, en_c, en_d;

  // stage A
  logic                     a_v_r;
  side_t                    a_side_r, a_side_nxt;
  logic [PROD_X_W-1:0]      a_prod_r, a_prod_nxt;
  logic signed [DIFF_W-1:0] a_diff_r, a_diff_nxt;

  // stage B
  logic                     b_v_r;
  side_t                    b_side_r, b_side_nxt;
  logic [NUM_W-1:0]         b_num_r, b_num_nxt;
  logic [RANGE_W-1:0]       b_rmag_r, b_rmag_nxt;
  logic                     b_rzero_r, b_rzero_nxt;

  // stage C
  logic                     c_v_r;
  side_t                    c_side_r, c_side_nxt;
  logic [NW-1:0]            c_dvd_r, c_dvd_nxt;
  logic [DW-1:0]            c_dsr_r, c_dsr_nxt;

  // stage D
  logic                     d_v_r;
  side_t                    d_side_r, d_side_nxt;
  logic [DW-1:0]            d_rem_r, d_rem_nxt;
  logic [MV_W-1:0]          d_qlo_r, d_qlo_nxt;
  logic [DW-1:0]            d_dsr_r;

  logic [PROD_X_W-1:0]      shifted;
  logic [DIFF_W-1:0]        dmag;
  logic signed [DIFF_W-1:0] rng;
  logic [DIFF_W-1:0]        rmag;
  logic [DW-1:0]            hi;

  assign en_d     = !d_v_r || out_ready;
  assign en_c     = !c_v_r || en_d;
  assign en_b     = !b_v_r || en_c;
  assign en_a     = !a_v_r || en_b;
  assign in_ready = en_a;

  always_comb begin
    a_side_nxt      = '0;
    a_side_nxt.mode = cfg_mode;
    a_side_nxt.raw  = MAX_COUNT_W'(in_count);
    a_prod_nxt      = PROD_X_W'(in_count) * PROD_X_W'(cfg_vref);
    a_diff_nxt      = $signed({1'b0, MAX_COUNT_W'(in_count)}) - $signed({1'b0, cfg_pmin});
  end

  always_comb begin
    shifted        = a_prod_r >> cfg_res;
    b_side_nxt     = a_side_r;
    b_side_nxt.big = |shifted[PROD_X_W-1:MV_W];
    b_side_nxt.u   = shifted[MV_W-1:0];
    dmag           = a_diff_r[DIFF_W-1] ? DIFF_W'(-a_diff_r) : DIFF_W'(a_diff_r);
    rng            = $signed({1'b0, cfg_pmax}) - $signed({1'b0, cfg_pmin});
    rmag           = rng[DIFF_W-1] ? DIFF_W'(-rng) : DIFF_W'(rng);
    b_side_nxt.neg = a_diff_r[DIFF_W-1] ^ rng[DIFF_W-1];
    b_num_nxt      = NUM_W'(dmag[RANGE_W-1:0]) * NUM_W'(PCT_FULL_Q8);
    b_rmag_nxt     = rmag[RANGE_W-1:0];
    b_rzero_nxt    = (cfg_pmax == cfg_pmin);
  end

  always_comb begin
    c_side_nxt = b_side_r;
    case (b_side_r.mode)
      MODE_DIV: begin
        c_dvd_nxt      = NW'(b_side_r.u) * NW'(cfg_r1);
        c_dsr_nxt      = DW'(cfg_r2);
        c_side_nxt.err = (cfg_r2 == '0);
      end
      MODE_PCT: begin
        c_dvd_nxt      = NW'(b_num_r);
        c_dsr_nxt      = DW'(b_rmag_r);
        c_side_nxt.err = b_rzero_r;
      end
      default: begin
        c_dvd_nxt      = NW'(b_num_r);
        c_dsr_nxt      = DW'(b_rmag_r);
        c_side_nxt.err = 1'b0;
      end
    endcase
  end

  always_comb begin
    hi             = DW'(c_dvd_r[NW-1:MV_W]);
    d_side_nxt     = c_side_r;
    d_side_nxt.ovf = (hi >= c_dsr_r);
    d_rem_nxt      = hi;
    d_qlo_nxt      = c_dvd_r[MV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else begin
      if (en_a) a_v_r <= in_valid;
      if (en_b) b_v_r <= a_v_r;
      if (en_c) c_v_r <= b_v_r;
      if (en_d) d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      a_side_r <= a_side_nxt;
      a_prod_r <= a_prod_nxt;
      a_diff_r <= a_diff_nxt;
    end
    if (en_b && a_v_r) begin
      b_side_r  <= b_side_nxt;
      b_num_r   <= b_num_nxt;
      b_rmag_r  <= b_rmag_nxt;
      b_rzero_r <= b_rzero_nxt;
    end
    if (en_c && b_v_r) begin
      c_side_r <= c_side_nxt;
      c_dvd_r  <= c_dvd_nxt;
      c_dsr_r  <= c_dsr_nxt;
    end
    if (en_d && c_v_r) begin
      d_side_r <= d_side_nxt;
      d_rem_r  <= d_rem_nxt;
      d_qlo_r  <= d_qlo_nxt;
      d_dsr_r  <= c_dsr_r;
    end
  end

  assign out_valid = d_v_r;
  assign out_rem   = d_rem_r;
  assign out_qlo   = d_qlo_r;
  assign out_dsr   = d_dsr_r;
  assign out_side  = d_side_r;

endmodule
`default_nettype wire

[rtl/acs_div_stage.sv]
// One restoring division step with its pipeline register.
`default_nettype none
module acs_div_stage #(
  parameter int DW = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [DW-1:0]            in_rem,
  input  wire logic [acs_pkg::MV_W-1:0] in_qlo,
  input  wire logic [DW-1:0]            in_dsr,
  input  wire acs_pkg::side_t           in_side,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [DW-1:0]                 out_rem,
  output logic [acs_pkg::MV_W-1:0]      out_qlo,
  output logic [DW-1:0]                 out_dsr,
  output acs_pkg::side_t                out_side
);
  import acs_pkg::*;

  logic            v_r;
  logic            en;
  logic [DW:0]     t;
  logic [DW:0]     dif;
  logic            ge;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [MV_W-1:0] qlo_r, qlo_nxt;
  logic [DW-1:0]   dsr_r;
  side_t           side_r;

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  always_comb begin
    t       = {in_rem, in_qlo[MV_W-1]};
    dif     = t - {1'b0, in_dsr};
    ge      = (t >= {1'b0, in_dsr});
    rem_nxt = ge ? dif[DW-1:0] : t[DW-1:0];
    qlo_nxt = {in_qlo[MV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      rem_r  <= rem_nxt;
      qlo_r  <= qlo_nxt;
      dsr_r  <= in_dsr;
      side_r <= in_side;
    end
  end

  assign out_valid = v_r;
  assign out_rem   = rem_r;
  assign out_qlo   = qlo_r;
  assign out_dsr   = dsr_r;
  assign out_side  = side_r;

endmodule
`default_nettype wire

[rtl/acs_post.sv]
// Result stage: sum, saturation, clamp and output register.
`default_nettype none
module acs_post #(
  parameter int COUNT_BITS = acs_pkg::DEF_COUNT_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [acs_pkg::MV_W-1:0]  in_quot,
  input  wire acs_pkg::side_t            in_side,
  input  wire logic                      cfg_clamp,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [COUNT_BITS-1:0]          out_count_echo,
  output logic [acs_pkg::MV_W-1:0]       out_millivolts,
  output logic signed [acs_pkg::PCT_W-1:0] out_percent_q8,
  output logic                           out_div_error
);
  import acs_pkg::*;

  localparam logic [PCT_W-1:0] PCT_POS_SAT = {1'b0, {(PCT_W-1){1'b1}}};
  localparam logic [PCT_W-1:0] PCT_NEG_SAT = {1'b1, {(PCT_W-1){1'b0}}};
  localparam logic [PCT_W-1:0] PCT_FULL    = PCT_W'(PCT_FULL_Q8);

  logic               v_r;
  logic               en;
  logic [MV_W:0]      total;
  logic               big31;
  logic [COUNT_BITS-1:0] raw_r;
  logic [MV_W-1:0]    mv_r, mv_nxt;
  logic [PCT_W-1:0]   pct_r, pct_nxt;
  logic               err_r;

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  always_comb begin
    total   = {1'b0, in_side.u} + {1'b0, in_quot};
    big31   = in_side.ovf || in_quot[MV_W-1];
    mv_nxt  = '0;
    pct_nxt = '0;
    case (in_side.mode)
      MODE_DIV: begin
        if (in_side.err) begin
          mv_nxt = '0;
        end else if (in_side.big || in_side.ovf || total[MV_W]) begin
          mv_nxt = '1;
        end else begin
          mv_nxt = total[MV_W-1:0];
        end
      end
      MODE_PCT: begin
        if (in_side.err) begin
          pct_nxt = '0;
        end else if (cfg_clamp) begin
          if (in_side.neg) begin
            pct_nxt = '0;
          end else if (big31 || (in_quot > PCT_FULL)) begin
            pct_nxt = PCT_FULL;
          end else begin
            pct_nxt = in_quot;
          end
        end else if (in_side.neg) begin
          pct_nxt = big31 ? PCT_NEG_SAT : PCT_W'(-in_quot);
        end else begin
          pct_nxt = big31 ? PCT_POS_SAT : in_quot;
        end
      end
      default: begin
        mv_nxt  = '0;
        pct_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      raw_r <= in_side.raw[COUNT_BITS-1:0];
      mv_r  <= mv_nxt;
      pct_r <= pct_nxt;
      err_r <= in_side.err;
    end
  end

  assign out_valid      = v_r;
  assign out_count_echo = raw_r;
  assign out_millivolts = mv_r;
  assign out_percent_q8 = $signed(pct_r);
  assign out_div_error  = err_r;

endmodule
`default_nettype wire

[rtl/adc_count_scaler_unit.sv]
// Top level of the ADC count scaler: config registers, front, divider chain, result stage.
//
//  channel | ports                          | transfer
//  in      | in_valid/in_ready              | one ADC count
//  out     | out_valid/out_ready            | one scaled result per count
//  cfg     | cfg_valid/cfg_ready            | one register write, always ready
//
// One count enters per cycle while the output is not stalled; the pipeline has four set-up stages,
// 32 one-bit restoring division stages and one result stage.
// Synchronous active-low reset empties the pipeline and loads register defaults.
// Each stage holds its item when the next is full, so bubbles close up on a stall.
`default_nettype none
module adc_count_scaler_unit #(
  parameter int COUNT_BITS    = acs_pkg::DEF_COUNT_BITS,
  parameter int RESISTOR_BITS = acs_pkg::DEF_RESISTOR_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [COUNT_BITS-1:0]          in_sample_count,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [COUNT_BITS-1:0]               out_count_echo,
  output logic [acs_pkg::MV_W-1:0]            out_millivolts,
  output logic signed [acs_pkg::PCT_W-1:0]    out_percent_q8,
  output logic                                out_div_error,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [acs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [acs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import acs_pkg::*;

  localparam int DW = (RESISTOR_BITS > RANGE_W) ? RESISTOR_BITS : RANGE_W;

  mode_t                  mode_r;
  logic [VREF_W-1:0]      vref_r;
  logic [RES_W-1:0]       res_r;
  logic [RESISTOR_BITS-1:0] r1_r;
  logic [RESISTOR_BITS-1:0] r2_r;
  logic [RANGE_W-1:0]     pmin_r;
  logic [RANGE_W-1:0]     pmax_r;
  logic                   clamp_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RAW;
      vref_r  <= RST_VREF;
      res_r   <= RST_RES;
      r1_r    <= '0;
      r2_r    <= RESISTOR_BITS'(1);
      pmin_r  <= RST_PMIN;
      pmax_r  <= RST_PMAX;
      clamp_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:  mode_r  <= mode_t'(cfg_wdata[1:0]);
        REG_VREF:  vref_r  <= cfg_wdata[VREF_W-1:0];
        REG_RES:   res_r   <= cfg_wdata[RES_W-1:0];
        REG_R1:    r1_r    <= RESISTOR_BITS'(cfg_wdata);
        REG_R2:    r2_r    <= RESISTOR_BITS'(cfg_wdata);
        REG_PMIN:  pmin_r  <= cfg_wdata[RANGE_W-1:0];
        REG_PMAX:  pmax_r  <= cfg_wdata[RANGE_W-1:0];
        REG_CLAMP: clamp_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic            vld [DIV_STEPS+1];
  logic            rdy [DIV_STEPS+1];
  logic [DW-1:0]   rem [DIV_STEPS+1];
  logic [MV_W-1:0] qlo [DIV_STEPS+1];
  logic [DW-1:0]   dsr [DIV_STEPS+1];
  side_t           sd  [DIV_STEPS+1];

  acs_front #(
    .COUNT_BITS   (COUNT_BITS),
    .RESISTOR_BITS(RESISTOR_BITS),
    .DW           (DW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_count (in_sample_count),
    .cfg_mode (mode_r),
    .cfg_vref (vref_r),
    .cfg_res  (res_r),
    .cfg_r1   (r1_r),
    .cfg_r2   (r2_r),
    .cfg_pmin (pmin_r),
    .cfg_pmax (pmax_r),
    .out_valid(vld[0]),
    .out_ready(rdy[0]),
    .out_rem  (rem[0]),
    .out_qlo  (qlo[0]),
    .out_dsr  (dsr[0]),
    .out_side (sd[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    acs_div_stage #(.DW(DW)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (vld[i]),
      .in_ready (rdy[i]),
      .in_rem   (rem[i]),
      .in_qlo   (qlo[i]),
      .in_dsr   (dsr[i]),
      .in_side  (sd[i]),
      .out_valid(vld[i+1]),
      .out_ready(rdy[i+1]),
      .out_rem  (rem[i+1]),
      .out_qlo  (qlo[i+1]),
      .out_dsr  (dsr[i+1]),
      .out_side (sd[i+1])
    );
  end

  acs_post #(.COUNT_BITS(COUNT_BITS)) u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (vld[DIV_STEPS]),
    .in_ready      (rdy[DIV_STEPS]),
    .in_quot       (qlo[DIV_STEPS]),
    .in_side       (sd[DIV_STEPS]),
    .cfg_clamp     (clamp_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_count_echo(out_count_echo),
    .out_millivolts(out_millivolts),
    .out_percent_q8(out_percent_q8),
    .out_div_error (out_div_error)
  );

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Testbench for the ADC count scaler: predicts every result and checks it against the block.
`default_nettype none
class scaler_scoreboard;
  typedef struct {
    logic [23:0] raw;
    logic [31:0] mv;
    logic [31:0] pct;
    logic        err;
  } scaled_t;

  logic [1:0]  mode;
  logic [15:0] vref;
  logic [4:0]  res;
  logic [23:0] r1, r2, pmin, pmax;
  logic        clamp;
  scaled_t     pending[$];
  int          fails;

  function new();
    mode = acs_pkg::MODE_RAW; vref = 16'd3300; res = 5'd12;
    r1 = 0; r2 = 1; pmin = 0; pmax = 24'hFFFFFF; clamp = 0; fails = 0;
  endfunction

  function void write_reg(acs_pkg::cfg_reg_t idx, logic [23:0] d);
    case (idx)
      acs_pkg::REG_MODE:  mode = d[1:0];
      acs_pkg::REG_VREF:  vref = d[15:0];
      acs_pkg::REG_RES:   res = d[4:0];
      acs_pkg::REG_R1:    r1 = d;
      acs_pkg::REG_R2:    r2 = d;
      acs_pkg::REG_PMIN:  pmin = d;
      acs_pkg::REG_PMAX:  pmax = d;
      default:            clamp = d[0];
    endcase
  endfunction

  function void note_sample(logic [23:0] cnt);
    scaled_t e;
    logic [63:0] u, tot;
    longint rng, num, q;
    e.raw = cnt; e.mv = 0; e.pct = 0; e.err = 0;
    if (mode == acs_pkg::MODE_PCT) begin
      rng = longint'(pmax) - longint'(pmin);
      if (rng == 0) e.err = 1;
      else begin
        num = (longint'(cnt) - longint'(pmin)) * 25600;
        q = num / rng;
        if (clamp) begin
          if (q < 0) q = 0;
          if (q > 25600) q = 25600;
        end
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        e.pct = q[31:0];
      end
    end else if (mode == acs_pkg::MODE_DIV) begin
      if (r2 == 0) e.err = 1;
      else begin
        u = (64'(cnt) * 64'(vref)) >> res;
        if (u > 64'hFFFFFFFF) e.mv = 32'hFFFFFFFF;
        else begin
          tot = u + (u * 64'(r1)) / 64'(r2);
          e.mv = (tot > 64'hFFFFFFFF) ? 32'hFFFFFFFF : tot[31:0];
        end
      end
    end
    pending.push_back(e);
  endfunction

  function void check_result(logic [23:0] raw, logic [31:0] mv, logic [31:0] pct, logic err);
    scaled_t e;
    if (pending.size() == 0) begin
      $error("unexpected result count_echo=%0h", raw);
      fails++;
      return;
    end
    e = pending.pop_front();
    if (raw !== e.raw) begin
      $error("count_echo exp %0h got %0h", e.raw, raw); fails++;
    end
    if (mv !== e.mv) begin
      $error("millivolts exp %0d got %0d", e.mv, mv); fails++;
    end
    if (pct !== e.pct) begin
      $error("percent_q8 exp %0d got %0d", $signed(e.pct), $signed(pct)); fails++;
    end
    if (err !== e.err) begin
      $error("div_error exp %0b got %0b", e.err, err); fails++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import acs_pkg::*;

  localparam int LATENCY   = 37;
  localparam int STALL_MAX = 200000;

  logic        clk = 0, rst_n = 0;
  logic        in_valid = 0, in_ready;
  logic [23:0] in_sample_count = 0;
  logic        out_valid, out_ready = 0;
  logic [23:0] out_count_echo;
  logic [31:0] out_millivolts;
  logic signed [31:0] out_percent_q8;
  logic        out_div_error;
  logic        cfg_valid = 0, cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [23:0] cfg_wdata = 0;

  scaler_scoreboard scaled = new();
  bit  calm;
  int  idle_cycles;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  adc_count_scaler_unit u_dut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      scaled.check_result(out_count_echo, out_millivolts, out_percent_q8, out_div_error);
    if (rst_n) out_ready <= calm || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // valid stays up between back-to-back writes; send_sample lowers it
  task automatic write_cfg(cfg_reg_t idx, logic [23:0] d);
    cfg_valid <= 1; cfg_index <= idx; cfg_wdata <= d;
    do @(posedge clk); while (!cfg_ready);
    scaled.write_reg(idx, d);
  endtask

  task automatic send_sample(logic [23:0] cnt);
    cfg_valid <= 0;
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_sample_count <= cnt;
    do @(posedge clk); while (!in_ready);
    scaled.note_sample(cnt);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (scaled.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_count();
    case ($urandom_range(3))
      0: return 24'hFFFFFF - 24'($urandom_range(3));
      1: return 24'($urandom_range(15));
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic random_config();
    write_cfg(REG_MODE, 24'($urandom_range(3)));
    write_cfg(REG_VREF, $urandom_range(1) ? 24'($urandom()) : 24'hFFFF);
    write_cfg(REG_RES, 24'($urandom_range(24)));
    write_cfg(REG_R1, $urandom_range(3) == 0 ? 24'hFFFFFF : 24'($urandom()));
    write_cfg(REG_R2, $urandom_range(7) == 0 ? 24'd0 : rand_count());
    write_cfg(REG_PMIN, rand_count());
    write_cfg(REG_PMAX, $urandom_range(7) == 0 ? scaled.pmin : rand_count());
    write_cfg(REG_CLAMP, 24'($urandom_range(1)));
  endtask

  initial begin
    calm = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // raw mode and defaults
    send_sample(24'd0); send_sample(24'hFFFFFF); send_sample(24'h123456);
    drain();
    // divider extremes, then zero r2
    write_cfg(REG_MODE, 24'(MODE_DIV)); write_cfg(REG_VREF, 24'hFFFF);
    write_cfg(REG_RES, 24'd0); write_cfg(REG_R1, 24'hFFFFFF); write_cfg(REG_R2, 24'd1);
    send_sample(24'hFFFFFF); send_sample(24'd1); send_sample(24'd0);
    drain();
    write_cfg(REG_RES, 24'd24); write_cfg(REG_R2, 24'd0);
    send_sample(24'hFFFFFF); send_sample(24'd7);
    drain();
    // percentage: clamp, unclamped, reversed range, empty range
    write_cfg(REG_MODE, 24'(MODE_PCT)); write_cfg(REG_PMIN, 24'd100);
    write_cfg(REG_PMAX, 24'd200);
    write_cfg(REG_CLAMP, 24'd1);
    send_sample(24'd0); send_sample(24'd150); send_sample(24'hFFFFFF);
    drain();
    write_cfg(REG_CLAMP, 24'd0); write_cfg(REG_PMAX, 24'd101);
    send_sample(24'hFFFFFF); send_sample(24'd0);
    drain();
    write_cfg(REG_PMAX, 24'd50);
    send_sample(24'd10); send_sample(24'hFFFFFF);
    drain();
    write_cfg(REG_PMAX, 24'd100);
    send_sample(24'd100); send_sample(24'd5);
    drain();
    write_cfg(REG_MODE, 24'd3);
    send_sample(24'hABCDEF);
    drain();
    for (int ph = 0; ph < 15; ph++) begin
      random_config();
      for (int k = 0; k < 100; k++) begin
        if (k == 0) calm = (ph % 4 == 3);
        else if (k == 60) calm = 0;
        send_sample(rand_count());
      end
      calm = 0;
      drain();
    end
    if (scaled.fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire

[adc_count_scaler_unit.f]
rtl/acs_pkg.sv
rtl/acs_front.sv
rtl/acs_div_stage.sv
rtl/acs_post.sv
rtl/adc_count_scaler_unit.sv
dv/tb_top.sv
